/* rtl/core/lgs_pkg.sv */
// Shared types and constants for the life generation stencil unit.
// Used by every module under rtl/core; has no dependencies of its own.
package lgs_pkg;

   localparam int MAX_WIDTH  = 512;
   localparam int MAX_HEIGHT = 512;

   // Size registers are 10 bits wide, as written through the csr port.
   localparam int SIZE_W = 10;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int LAG_W  = SIZE_W + 1;
   localparam int CSR_INDEX_W = 8;

   localparam logic [SIZE_W-1:0] MIN_SIZE       = SIZE_W'(3);
   localparam logic [SIZE_W-1:0] WIDTH_RESET    = SIZE_W'(315);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET   = SIZE_W'(165);
   localparam logic [SIZE_W-1:0] MAX_WIDTH_VAL  = SIZE_W'(MAX_WIDTH);
   localparam logic [SIZE_W-1:0] MAX_HEIGHT_VAL = SIZE_W'(MAX_HEIGHT);

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_HEIGHT = CSR_INDEX_W'(1);

   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // One taken raster position on its way from the counters to the evaluator.
   typedef struct packed {
      logic             valid;
      logic             alive;
      logic [COL_W-1:0] col;
      logic             col_zero;
      logic             emit;
      logic             top;
      logic             bottom;
      logic             left;
      logic             right;
      logic             last;
   } slot_type;

   typedef struct packed {
      logic next_alive;
      logic cell_changed;
      logic frame_changed;
      logic last_of_frame;
   } result_type;

endpackage

/* rtl/core/lgs_line_buffer.sv */
// Two row buffers of the stencil, kept as one 2-bit wide memory.
// Bit 1 holds the row just received, bit 0 the row before it. Uses lgs_pkg.
module lgs_line_buffer import lgs_pkg::*; (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   output logic [1:0]       rd_data,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  logic [1:0]       wr_data
);

   logic [1:0] mem [MAX_WIDTH];
   logic [1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lgs_control.sv */
// Raster position counters, size registers and the lag count of the stencil.
// Decides for each beat where it lands and which result it releases. Uses lgs_pkg.
module lgs_control import lgs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   kind,
   input  logic                   cell_alive,
   input  logic                   slot_move,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_wdata,
   output logic                   taken,
   output logic [COL_W-1:0]       col,
   output logic                   restart,
   output slot_type               slot
);

   logic [SIZE_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [COL_W-1:0]  icol_ff, icol_in, ocol_ff, ocol_in;
   logic [ROW_W-1:0]  irow_ff, irow_in, orow_ff, orow_in;
   logic [LAG_W-1:0]  lag_ff, lag_in, lag_step;
   logic              cae_ff, cae_in;
   slot_type          slot_ff, slot_in;
   logic [SIZE_W-1:0] icol_next, irow_next, ocol_next, orow_next;
   logic              emit, out_bottom, out_right;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
      logic [SIZE_W-1:0] r;
      if (v < MIN_SIZE) begin
         r = MIN_SIZE;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign col   = ({1'b0, icol_ff} >= width_ff) ? '0 : icol_ff;
   assign taken = (kind == KIND_CELL) || (lag_ff != '0);
   assign restart = csr_write &&
                    ((csr_index == CSR_GRID_WIDTH) || (csr_index == CSR_GRID_HEIGHT));

   assign icol_next  = SIZE_W'(col) + SIZE_W'(1);
   assign irow_next  = SIZE_W'(irow_ff) + SIZE_W'(1);
   assign ocol_next  = SIZE_W'(ocol_ff) + SIZE_W'(1);
   assign orow_next  = SIZE_W'(orow_ff) + SIZE_W'(1);
   assign lag_step   = lag_ff + LAG_W'(1);
   assign emit       = lag_step >= (LAG_W'(width_ff) + LAG_W'(2));
   assign out_bottom = orow_next >= height_ff;
   assign out_right  = ocol_next >= width_ff;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      icol_in   = icol_ff;
      irow_in   = irow_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      lag_in    = lag_ff;
      cae_in    = cae_ff;

      slot_in = slot_ff;
      if (slot_move) begin
         slot_in.valid = 1'b0;
      end

      if (accept && taken) begin
         slot_in.valid    = 1'b1;
         slot_in.alive    = (kind == KIND_CELL) && cell_alive;
         slot_in.col      = col;
         slot_in.col_zero = (col == '0);
         slot_in.emit     = emit;
         slot_in.top      = (orow_ff == '0);
         slot_in.bottom   = out_bottom;
         slot_in.left     = (ocol_ff == '0);
         slot_in.right    = out_right;
         slot_in.last     = emit && out_bottom && out_right;

         if (kind == KIND_CELL) begin
            cae_in = 1'b1;
         end
         if (icol_next >= width_ff) begin
            icol_in = '0;
            if (irow_next >= height_ff) begin
               irow_in = '0;
               cae_in  = 1'b0;
            end else begin
               irow_in = irow_next[ROW_W-1:0];
            end
         end else begin
            icol_in = icol_next[COL_W-1:0];
         end

         if (emit) begin
            lag_in = lag_ff;
            if (out_bottom && out_right) begin
               orow_in = '0;
               ocol_in = '0;
               // With no cell seen past the frame end, the input side starts over.
               if (!cae_in) begin
                  irow_in = '0;
                  icol_in = '0;
                  lag_in  = '0;
               end
            end else if (out_right) begin
               ocol_in = '0;
               orow_in = orow_next[ROW_W-1:0];
            end else begin
               ocol_in = ocol_next[COL_W-1:0];
            end
         end else begin
            lag_in = lag_step;
         end
      end

      if (csr_write && (csr_index == CSR_GRID_WIDTH)) begin
         width_in = clamp_size(csr_wdata, MAX_WIDTH_VAL);
      end
      if (csr_write && (csr_index == CSR_GRID_HEIGHT)) begin
         height_in = clamp_size(csr_wdata, MAX_HEIGHT_VAL);
      end
      if (restart) begin
         icol_in       = '0;
         irow_in       = '0;
         ocol_in       = '0;
         orow_in       = '0;
         lag_in        = '0;
         cae_in        = 1'b0;
         slot_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         icol_ff       <= '0;
         irow_ff       <= '0;
         ocol_ff       <= '0;
         orow_ff       <= '0;
         lag_ff        <= '0;
         cae_ff        <= 1'b0;
         slot_ff       <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         icol_ff   <= icol_in;
         irow_ff   <= irow_in;
         ocol_ff   <= ocol_in;
         orow_ff   <= orow_in;
         lag_ff    <= lag_in;
         cae_ff    <= cae_in;
         slot_ff   <= slot_in;
      end
   end

   assign slot = slot_ff;

endmodule

/* rtl/core/lgs_window_eval.sv */
// 3x3 neighborhood window, edge masking and the B3/S23 rule.
// Also keeps the per-frame change flag. Uses lgs_pkg.
module lgs_window_eval import lgs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       restart,
   input  slot_type   slot,
   input  logic       slot_move,
   input  logic [1:0] buf_data,
   output result_type result
);

   localparam logic [8:0] MASK_TOP    = 9'h049;
   localparam logic [8:0] MASK_BOTTOM = 9'h124;
   localparam logic [8:0] MASK_LEFT   = 9'h007;
   localparam logic [8:0] MASK_RIGHT  = 9'h1C0;

   logic [8:0] window_ff, window_in;
   logic       change_ff, change_in;
   logic [8:0] win_new, win_sel, mask, win;
   logic [3:0] count;
   logic       center, next_alive, changed;

   // Each window column holds, from the low bit up: two rows back, one row back, new row.
   assign win_new = {slot.alive, buf_data[1], buf_data[0], window_ff[8:3]};

   // At column zero the emitted cell is the last one of the previous row.
   assign win_sel = slot.col_zero ? {3'b000, window_ff[8:3]} : win_new;

   always_comb begin
      mask = 9'h1FF;
      if (slot.top) begin
         mask = mask & ~MASK_TOP;
      end
      if (slot.bottom) begin
         mask = mask & ~MASK_BOTTOM;
      end
      if (slot.left) begin
         mask = mask & ~MASK_LEFT;
      end
      if (slot.right) begin
         mask = mask & ~MASK_RIGHT;
      end
   end

   assign win    = win_sel & mask;
   assign center = win[4];

   always_comb begin
      count = '0;
      for (int b = 0; b < 9; b++) begin
         if (b != 4) begin
            count = count + 4'(win[b]);
         end
      end
   end

   assign next_alive = center ? ((count == 4'd2) || (count == 4'd3)) : (count == 4'd3);
   assign changed    = next_alive ^ center;

   always_comb begin
      window_in = window_ff;
      change_in = change_ff;
      if (slot_move) begin
         window_in = win_new;
         if (slot.emit) begin
            change_in = slot.last ? 1'b0 : (change_ff | changed);
         end
      end
      if (restart) begin
         window_in = '0;
         change_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         change_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         change_ff <= change_in;
      end
   end

   assign result.next_alive    = next_alive;
   assign result.cell_changed  = changed;
   assign result.frame_changed = slot.last && (change_ff || changed);
   assign result.last_of_frame = slot.last;

endmodule

/* rtl/core/life_generation_stencil_unit.sv */
// Streaming B3/S23 next-generation stencil: cells arrive in raster order, one per beat,
// and the unit takes one beat in every clock cycle while the result side keeps up. The
// result for a cell leaves after one further row plus one cell has been taken, then
// passes the line buffer read register and the result register; flush beats push the
// tail of a frame out. The rate is set by the single port pair of the 512 x 2 line
// buffer, read and written once per beat. No clearing pass follows reset: neighbors
// outside the frame are masked by the output position, so the buffer's power-up
// contents are never seen. Writing either size register restarts the raster
// position; sizes are clamped to 3..512. Depends on lgs_pkg and the lgs modules.
module life_generation_stencil_unit import lgs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,   // [0] cell_alive, [7:1] zero
   input  logic                   req_tuser,   // [0] kind
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [7:0]             rsp_tdata,   // [0] next_alive, [1] cell_changed,
                                               // [2] frame_changed, [7:3] zero
   output logic                   rsp_tlast,   // last_of_frame
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_wdata
);

   logic       accept, taken, restart, slot_move;
   logic [COL_W-1:0] col;
   slot_type   slot;
   logic [1:0] buf_data;
   result_type result;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign csr_ready = 1'b1;

   // A slot that releases no result never waits for the result register.
   assign slot_move  = slot.valid && (!slot.emit || !rsp_valid_ff || rsp_tready);
   assign req_tready = !slot.valid || slot_move;
   assign accept     = req_tvalid && req_tready;

   lgs_control u_control (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .kind       (req_tuser),
      .cell_alive (req_tdata[0]),
      .slot_move  (slot_move),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .taken      (taken),
      .col        (col),
      .restart    (restart),
      .slot       (slot)
   );

   lgs_line_buffer u_line_buffer (
      .clock   (clock),
      .rd_en   (accept && taken),
      .rd_addr (col),
      .rd_data (buf_data),
      .wr_en   (slot_move),
      .wr_addr (slot.col),
      .wr_data ({slot.alive, buf_data[1]})
   );

   lgs_window_eval u_window_eval (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .slot      (slot),
      .slot_move (slot_move),
      .buf_data  (buf_data),
      .result    (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (slot_move && slot.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_ff.frame_changed, rsp_ff.cell_changed,
                        rsp_ff.next_alive};
   assign rsp_tlast  = rsp_ff.last_of_frame;

   // The buffer entry being written back must never be the one read for the next beat.
   // After a frame drained by flush beats the input restarts at column zero, and the
   // first read may meet the write of the last slot; that row is masked as the top edge.
   a_no_buffer_collision: assert property (@(posedge clock) disable iff (reset)
      (accept && taken && slot_move && !slot.last) |-> (col != slot.col))
      else $error("line buffer read and write collide on one column");

   // A waiting result is never overwritten by the next one.
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(slot_move && slot.emit))
      else $error("pending result overwritten");

   // The frame change flag is only reported on the last cell of a frame.
   a_frame_flag_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[2] || rsp_tlast))
      else $error("frame_changed set outside the last cell");

endmodule

/* tb/life_generation_stencil_checker.sv */
// Checker for the life generation stencil unit: watches the cell, result and size-register
// channels, predicts each next-generation result and compares it with the result beat.
// Depends on lgs_pkg for sizes, register indexes and the result layout.
module life_generation_stencil_checker import lgs_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [7:0]             rsp_tdata,
   input  logic                   rsp_tlast,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]      csr_wdata,
   output int                     error_count,
   output int                     pending,
   output int                     result_beats,
   output int                     frames_done,
   output int                     frames_changed,
   output int                     size_writes
);
   timeunit 1ns;
   timeprecision 1ps;

   // Window bits: each column holds {row below, this row, row above} from bit 2 down,
   // and the oldest column sits in the lowest bits.
   localparam logic [8:0] ABOVE_ROW_BITS = 9'h049;
   localparam logic [8:0] BELOW_ROW_BITS = 9'h124;
   localparam logic [8:0] LEFT_COL_BITS  = 9'h007;
   localparam logic [8:0] RIGHT_COL_BITS = 9'h1C0;
   localparam logic [8:0] CENTER_BIT     = 9'h010;

   int         grid_cols;
   int         grid_rows;
   logic       above_line [MAX_WIDTH];
   logic       current_line [MAX_WIDTH];
   logic [8:0] window;
   int         in_col;
   int         in_row;
   int         out_col;
   int         out_row;
   int         lag;
   logic       frame_dirty;
   logic       cell_since_wrap;
   result_type next_gen_q [$];

   function automatic int clamp_dim(int value, int hi);
      if (value < MIN_SIZE) return MIN_SIZE;
      if (value > hi) return hi;
      return value;
   endfunction

   task automatic restart_raster();
      window          = '0;
      in_col          = 0;
      in_row          = 0;
      out_col         = 0;
      out_row         = 0;
      lag             = 0;
      frame_dirty     = 1'b0;
      cell_since_wrap = 1'b0;
   endtask

   task automatic report_mismatch(string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // Takes one accepted beat into the line buffers and queues the result it releases.
   task automatic take_cell(logic is_flush, logic alive);
      int         col;
      int         neighbors;
      logic       above;
      logic       cur;
      logic       fresh;
      logic       center;
      logic       last;
      logic [8:0] prev;
      logic [8:0] win;
      logic [8:0] mask;
      result_type r;
      fresh = alive;
      if (is_flush) begin
         // A bubble only counts while something is still in flight.
         if (lag == 0) return;
         fresh = 1'b0;
      end
      col = in_col;
      if (col >= grid_cols || col >= MAX_WIDTH) col = 0;
      prev = window;
      above = above_line[col];
      cur = current_line[col];
      above_line[col] = cur;
      current_line[col] = fresh;
      window = (prev >> 3) | {fresh, cur, above, 6'b0};
      lag++;
      if (!is_flush) cell_since_wrap = 1'b1;
      in_col = col + 1;
      if (in_col >= grid_cols) begin
         in_col = 0;
         in_row++;
         if (in_row >= grid_rows) begin
            in_row = 0;
            cell_since_wrap = 1'b0;
         end
      end
      if (lag < grid_cols + 2) return;
      lag--;

      // At column zero the cell being released is the last one of the previous row.
      win = (col == 0) ? (prev >> 3) : window;
      mask = '1;
      if (out_row == 0) mask &= ~ABOVE_ROW_BITS;
      if (out_row + 1 >= grid_rows) mask &= ~BELOW_ROW_BITS;
      if (out_col == 0) mask &= ~LEFT_COL_BITS;
      if (out_col + 1 >= grid_cols) mask &= ~RIGHT_COL_BITS;
      win &= mask;

      center = |(win & CENTER_BIT);
      neighbors = $countones(win & ~CENTER_BIT);
      r.next_alive = center ? (neighbors == 2 || neighbors == 3) : (neighbors == 3);
      r.cell_changed = r.next_alive ^ center;
      if (r.cell_changed) frame_dirty = 1'b1;
      last = (out_row + 1 >= grid_rows) && (out_col + 1 >= grid_cols);
      r.frame_changed = last && frame_dirty;
      r.last_of_frame = last;
      next_gen_q.push_back(r);

      if (last) begin
         out_row = 0;
         out_col = 0;
         frame_dirty = 1'b0;
         // With no cell after the frame's end, the tail was pushed out by bubbles alone.
         if (!cell_since_wrap) begin
            in_row = 0;
            in_col = 0;
            lag = 0;
         end
      end else begin
         out_col++;
         if (out_col >= grid_cols) begin
            out_col = 0;
            out_row++;
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            above_line[i] = 1'b0;
            current_line[i] = 1'b0;
         end
         grid_cols = clamp_dim(WIDTH_RESET, MAX_WIDTH);
         grid_rows = clamp_dim(HEIGHT_RESET, MAX_HEIGHT);
         restart_raster();
         next_gen_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            result_beats++;
            if (next_gen_q.size() == 0) begin
               report_mismatch("result beat with no cell awaiting it");
            end else begin
               want = next_gen_q.pop_front();
               if (rsp_tdata[0] !== want.next_alive)
                  report_mismatch($sformatf("next_alive %b, expected %b",
                                            rsp_tdata[0], want.next_alive));
               if (rsp_tdata[1] !== want.cell_changed)
                  report_mismatch($sformatf("cell_changed %b, expected %b",
                                            rsp_tdata[1], want.cell_changed));
               if (rsp_tdata[2] !== want.frame_changed)
                  report_mismatch($sformatf("frame_changed %b, expected %b",
                                            rsp_tdata[2], want.frame_changed));
               if (rsp_tlast !== want.last_of_frame)
                  report_mismatch($sformatf("last_of_frame %b, expected %b",
                                            rsp_tlast, want.last_of_frame));
               if (rsp_tdata[7:3] !== '0)
                  report_mismatch($sformatf("padding bits %b not zero", rsp_tdata[7:3]));
               if (want.last_of_frame) begin
                  frames_done++;
                  if (want.frame_changed) frames_changed++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_WIDTH) begin
               grid_cols = clamp_dim(csr_wdata, MAX_WIDTH);
               restart_raster();
               size_writes++;
            end else if (csr_index == CSR_GRID_HEIGHT) begin
               grid_rows = clamp_dim(csr_wdata, MAX_HEIGHT);
               restart_raster();
               size_writes++;
            end
         end
         if (req_tvalid && req_tready) take_cell(req_tuser == KIND_FLUSH, req_tdata[0]);
      end
      pending = next_gen_q.size();
   end

endmodule

/* tb/tb_life_generation_stencil_unit.sv */
// Top of the life generation stencil unit testbench: clock, reset, cell stimulus, result
// back-pressure and size writes, with the checker instantiated beside the unit.
// Depends on lgs_pkg, the unit's RTL and life_generation_stencil_checker.
module tb_life_generation_stencil_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import lgs_pkg::*;

   localparam int CYCLE_LIMIT  = 500_000;
   localparam int LONG_HOLD    = 300;
   localparam int RANDOM_BEATS = 200;
   localparam int CALM_BEATS   = 60;
   localparam int SIZE_CODES   = 2 ** SIZE_W;

   // Indexes outside the register map; writes there must leave the unit alone.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LOW = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_TOP = '1;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [0] cell_alive, [7:1] zero
   logic                   req_tuser;   // [0] kind
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;   // [0] next_alive, [1] cell_changed,
                                        // [2] frame_changed, [7:3] zero
   logic                   rsp_tlast;   // last_of_frame
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [SIZE_W-1:0]      csr_wdata;

   int          error_count;
   int          pending;
   int          result_beats;
   int          frames_done;
   int          frames_changed;
   int          size_writes;
   int          beats_sent;
   int unsigned cycle_count;
   logic        stall_bursts;
   logic        long_hold_req;

   life_generation_stencil_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   life_generation_stencil_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .error_count    (error_count),
      .pending        (pending),
      .result_beats   (result_beats),
      .frames_done    (frames_done),
      .frames_changed (frames_changed),
      .size_writes    (size_writes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("== FAIL ==");
      $finish;
   end

   // Result side: random stall bursts, plus one long hold-off on request.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Leaves tvalid high after the beat is taken; the next call or a size write
   // lowers it or replaces the data at the following falling edge.
   task automatic send_beat(logic kind, logic alive);
      @(negedge clock);
      if (stall_bursts && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'b0, alive};
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic send_cells(int count, int density, int bubble_pct);
      repeat (count) begin
         if ($urandom_range(0, 99) < bubble_pct)
            send_beat(KIND_FLUSH, 1'($urandom_range(0, 1)));
         else
            send_beat(KIND_CELL, $urandom_range(0, 99) < density);
      end
   endtask

   // One row plus one cell of bubbles pushes the whole tail out; the extras are ignored.
   task automatic drain(int cols);
      repeat (cols + 1 + $urandom_range(0, 2)) send_beat(KIND_FLUSH, 1'($urandom_range(0, 1)));
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [SIZE_W-1:0] value);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (8) @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sizes at the ends of the range are sometimes written as values the unit clamps.
   function automatic logic [SIZE_W-1:0] size_code(int dim, int hi);
      if (dim == MIN_SIZE && $urandom_range(0, 2) == 0)
         return SIZE_W'($urandom_range(0, MIN_SIZE));
      if (dim == hi && $urandom_range(0, 1) == 1)
         return SIZE_W'($urandom_range(hi, SIZE_CODES - 1));
      return SIZE_W'(dim);
   endfunction

   task automatic set_grid(int cols, int rows);
      logic [SIZE_W-1:0] raw_cols;
      logic [SIZE_W-1:0] raw_rows;
      raw_cols = size_code(cols, MAX_WIDTH);
      raw_rows = size_code(rows, MAX_HEIGHT);
      if ($urandom_range(0, 1) == 1) begin
         write_reg(CSR_GRID_WIDTH, raw_cols);
         write_reg(CSR_GRID_HEIGHT, raw_rows);
      end else begin
         write_reg(CSR_GRID_HEIGHT, raw_rows);
         write_reg(CSR_GRID_WIDTH, raw_cols);
      end
   endtask

   initial begin
      int         cols;
      int         rows;
      int         pick;
      int         start;
      logic [8:0] blinker;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = KIND_CELL;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      stall_bursts  = 1'b1;
      long_hold_req = 1'b0;
      cycle_count   = 0;
      beats_sent    = 0;
      blinker       = 9'b010_010_010;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Bubbles with nothing in flight are dropped; a few cells at the reset size are
      // then lost when the size write restarts the raster.
      repeat (3) send_beat(KIND_FLUSH, 1'($urandom_range(0, 1)));
      send_cells(4, 50, 0);
      write_reg(CSR_GRID_WIDTH, '0);
      write_reg(CSR_GRID_HEIGHT, SIZE_W'(2));

      // Smallest grid: all alive, then a blinker followed directly by a frame with a
      // bubble standing in for its center cell.
      send_cells(9, 100, 0);
      drain(3);
      for (int i = 0; i < 9; i++) send_beat(KIND_CELL, blinker[i]);
      for (int i = 0; i < 9; i++) begin
         if (i == 4) send_beat(KIND_FLUSH, 1'b1);
         else send_beat(KIND_CELL, blinker[i]);
      end
      drain(3);
      write_reg(CSR_UNUSED_LOW, '1);
      write_reg(CSR_UNUSED_TOP, '0);
      send_cells(9, 0, 0);
      drain(3);

      // Widest and tallest grids: the first rows of each, cut short by the next write.
      write_reg(CSR_GRID_WIDTH, '1);
      write_reg(CSR_GRID_HEIGHT, MIN_SIZE);
      send_cells(MAX_WIDTH + 16, 35, 0);
      set_grid(3, MAX_HEIGHT);
      send_cells(3 * 10, 35, 0);

      // Long hold-off on the result side while cells keep coming, then a pause on the
      // cell side until every queued result has come out.
      set_grid(8, 8);
      long_hold_req = 1'b1;
      send_cells(64, 40, 0);
      drain(8);
      set_grid(8, 6);
      send_cells(20, 40, 0);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      send_cells(28, 40, 0);
      drain(8);

      start = beats_sent;
      while (beats_sent - start < RANDOM_BEATS) begin
         pick = $urandom_range(0, 9);
         cols = (pick == 0) ? $urandom_range(11, 24) : $urandom_range(3, 10);
         rows = (pick == 1) ? $urandom_range(11, 16) : $urandom_range(3, 8);
         stall_bursts = (beats_sent - start < RANDOM_BEATS - CALM_BEATS) &&
                        $urandom_range(0, 3) != 0;
         set_grid(cols, rows);
         repeat ($urandom_range(1, 2)) begin
            pick = $urandom_range(0, 4);
            send_cells(cols * rows,
                       (pick == 0) ? 0 : (pick == 1) ? 100 : $urandom_range(20, 60),
                       ($urandom_range(0, 3) == 0) ? 5 : 0);
         end
         // Now and then the next size write cuts a frame short.
         if ($urandom_range(0, 5) == 0) send_cells($urandom_range(1, cols * rows - 1), 40, 0);
         else drain(cols);
      end

      stall_bursts = 1'b0;
      set_grid(4, 3);
      send_cells(12, 40, 0);
      drain(4);
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (pending == 0);
      repeat (20) @(posedge clock);

      $display("Covered %0d beats in, %0d result beats, %0d frames (%0d with changes).",
               beats_sent, result_beats, frames_done, frames_changed);
      $display("Grid size was written %0d times, from 3x3 up to 512 cells per side.",
               size_writes);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
